FILE: hw/rtl/gae_pkg.sv
`default_nettype none
package gae_pkg;

  localparam int KIND_W           = 2;
  localparam int VERTEX_W         = 5;
  localparam int SET_W            = 32;
  localparam int COUNT_W          = 6;
  localparam int TOTAL_W          = 9;
  localparam int ROW_LIMIT        = 32;
  localparam int DEF_MAX_VERTICES = 32;
  localparam logic [COUNT_W-1:0] COUNT_RESET = 6'd32;

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_CLIQUE = 2'd2,
    KIND_PATH   = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t               kind;
    logic [VERTEX_W-1:0] vertex_a;
    logic [VERTEX_W-1:0] vertex_b;
    logic [VERTEX_W-1:0] path_from;
    logic [VERTEX_W-1:0] path_to;
    logic [SET_W-1:0]    vertex_set;
    logic [SET_W-1:0]    blocked_set;
  } item_t;

  typedef struct packed {
    logic               answer;
    logic               status;
    logic [TOTAL_W-1:0] edge_total;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_EDGE_A,
    ST_EDGE_B,
    ST_SWEEP,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic                rd_en;
    logic [VERTEX_W-1:0] rd_addr;
    logic                wr_en;
    logic [VERTEX_W-1:0] wr_addr;
    logic [SET_W-1:0]    wr_data;
  } mem_req_t;

  typedef struct packed {
    logic             clique_fail;
    logic [SET_W-1:0] path_next;
  } unit_res_t;

endpackage
`default_nettype wire

FILE: hw/rtl/gae_adj_mem.sv
`default_nettype none
module gae_adj_mem #(
  parameter int ROWS = gae_pkg::ROW_LIMIT
) (
  input  logic                     clk,
  input  logic                     rst,
  input  gae_pkg::mem_req_t        req,
  output logic [gae_pkg::SET_W-1:0] rd_data
);
  import gae_pkg::*;

  localparam int ROW_AW = $clog2(ROWS);

  logic [SET_W-1:0] mem [ROWS];
  logic [ROWS-1:0]  row_valid;
  logic [SET_W-1:0] rd_q;
  logic             rd_hit;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr[ROW_AW-1:0]] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_q <= mem[req.rd_addr[ROW_AW-1:0]];
    end
  end

  // rows never written read as empty
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      rd_hit    <= 1'b0;
    end else begin
      if (req.wr_en) begin
        row_valid[req.wr_addr[ROW_AW-1:0]] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_hit <= row_valid[req.rd_addr[ROW_AW-1:0]];
      end
    end
  end

  assign rd_data = rd_hit ? rd_q : '0;

endmodule
`default_nettype wire

FILE: hw/rtl/gae_row_unit.sv
`default_nettype none
module gae_row_unit (
  input  logic [gae_pkg::SET_W-1:0]    row,
  input  logic [gae_pkg::VERTEX_W-1:0] idx,
  input  logic [gae_pkg::SET_W-1:0]    vertex_set,
  input  logic [gae_pkg::SET_W-1:0]    blocked_set,
  input  logic [gae_pkg::SET_W-1:0]    vmask,
  input  logic [gae_pkg::VERTEX_W-1:0] vertex_a,
  input  logic [gae_pkg::VERTEX_W-1:0] vertex_b,
  input  logic [gae_pkg::SET_W-1:0]    reached,
  output gae_pkg::unit_res_t           res
);
  import gae_pkg::*;

  logic [SET_W-1:0] need;
  logic [SET_W-1:0] nb;

  always_comb begin
    need = vertex_set & ~(SET_W'(1) << idx);
    res.clique_fail = vertex_set[idx] && ((row & need) != need);

    nb = row & vmask & ~blocked_set;
    if (vertex_a != vertex_b) begin
      if (idx == vertex_a) begin
        nb = nb & ~(SET_W'(1) << vertex_b);
      end
      if (idx == vertex_b) begin
        nb = nb & ~(SET_W'(1) << vertex_a);
      end
    end
    res.path_next = reached[idx] ? (reached | nb) : reached;
  end

endmodule
`default_nettype wire

FILE: hw/rtl/gae_ctrl.sv
`default_nettype none
module gae_ctrl #(
  parameter int MAX_VERTICES = gae_pkg::DEF_MAX_VERTICES
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  gae_pkg::item_t              item,
  output logic                        done,
  output gae_pkg::result_t            result,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [gae_pkg::COUNT_W-1:0] cfg_data,
  output gae_pkg::mem_req_t           mem_req,
  input  logic [gae_pkg::SET_W-1:0]   rd_data
);
  import gae_pkg::*;

  localparam int ROWS = (MAX_VERTICES < ROW_LIMIT) ? MAX_VERTICES : ROW_LIMIT;
  localparam logic [COUNT_W:0]   MAX_C  = (COUNT_W + 1)'(MAX_VERTICES);
  localparam logic [COUNT_W-1:0] ROWS_C = COUNT_W'(ROWS);

  state_t               state, state_next;
  logic [COUNT_W-1:0]   vertex_count;
  item_t                cur, cur_next;
  logic [TOTAL_W-1:0]   edge_counter, edge_counter_next;
  logic                 answer, answer_next;
  logic                 status, status_next;
  logic [COUNT_W-1:0]   idx, idx_next;
  logic [SET_W-1:0]     reached, reached_next;
  logic                 grew, grew_next;
  logic                 rd_pend;
  logic [VERTEX_W-1:0]  rd_idx;

  logic [COUNT_W-1:0]   cnt;
  logic [COUNT_W-1:0]   lim;
  logic [SET_W-1:0]     vmask;
  logic                 last;
  logic                 present;
  logic                 grow_now;
  unit_res_t            unit_res;

  always_comb begin
    if (vertex_count == '0) begin
      cnt = COUNT_W'(1);
    end else if ({1'b0, vertex_count} > MAX_C) begin
      cnt = MAX_C[COUNT_W-1:0];
    end else begin
      cnt = vertex_count;
    end
    lim   = (cnt > ROWS_C) ? ROWS_C : cnt;
    vmask = (cnt >= COUNT_W'(SET_W)) ? '1 : SET_W'((33'd1 << cnt) - 33'd1);
  end

  gae_row_unit u_unit (
    .row         (rd_data),
    .idx         (rd_idx),
    .vertex_set  (cur.vertex_set),
    .blocked_set (cur.blocked_set),
    .vmask       (vmask),
    .vertex_a    (cur.vertex_a),
    .vertex_b    (cur.vertex_b),
    .reached     (reached),
    .res         (unit_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      vertex_count <= COUNT_RESET;
      edge_counter <= '0;
      rd_pend      <= 1'b0;
    end else begin
      state        <= state_next;
      edge_counter <= edge_counter_next;
      rd_pend      <= mem_req.rd_en;
      if (cfg_valid && cfg_ready) begin
        vertex_count <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur     <= cur_next;
    answer  <= answer_next;
    status  <= status_next;
    idx     <= idx_next;
    reached <= reached_next;
    grew    <= grew_next;
    rd_idx  <= mem_req.rd_addr;
  end

  always_comb begin
    state_next        = state;
    cur_next          = cur;
    edge_counter_next = edge_counter;
    answer_next       = answer;
    status_next       = status;
    idx_next          = idx;
    reached_next      = reached;
    grew_next         = grew;
    mem_req           = '0;
    busy              = 1'b1;
    done              = 1'b0;
    present           = rd_data[cur.vertex_b];
    last              = ({1'b0, rd_idx} == (lim - COUNT_W'(1)));
    grow_now          = (unit_res.path_next != reached);

    case (state)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cur_next   = item;
          state_next = ST_CHECK;
        end
      end

      ST_CHECK: begin
        status_next = 1'b0;
        answer_next = 1'b0;
        case (cur.kind)
          KIND_INSERT, KIND_REMOVE: begin
            if (({1'b0, cur.vertex_a} >= cnt) || ({1'b0, cur.vertex_b} >= cnt)) begin
              status_next = 1'b1;
              state_next  = ST_DONE;
            end else if (cur.vertex_a == cur.vertex_b) begin
              state_next = ST_DONE;
            end else begin
              mem_req.rd_en   = 1'b1;
              mem_req.rd_addr = cur.vertex_a;
              state_next      = ST_EDGE_A;
            end
          end
          KIND_CLIQUE: begin
            if ((cur.vertex_set & ~vmask) != '0) begin
              status_next = 1'b1;
              state_next  = ST_DONE;
            end else begin
              answer_next = 1'b1;
              idx_next    = '0;
              state_next  = ST_SWEEP;
            end
          end
          default: begin
            if (({1'b0, cur.path_from} >= cnt) || ({1'b0, cur.path_to} >= cnt)) begin
              status_next = 1'b1;
              state_next  = ST_DONE;
            end else if (cur.path_from == cur.path_to) begin
              answer_next = 1'b1;
              state_next  = ST_DONE;
            end else begin
              reached_next = SET_W'(1) << cur.path_from;
              grew_next    = 1'b0;
              idx_next     = '0;
              state_next   = ST_SWEEP;
            end
          end
        endcase
      end

      ST_EDGE_A: begin
        if ((cur.kind == KIND_INSERT) != present) begin
          mem_req.wr_en   = 1'b1;
          mem_req.wr_addr = cur.vertex_a;
          mem_req.wr_data = rd_data ^ (SET_W'(1) << cur.vertex_b);
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = cur.vertex_b;
          edge_counter_next = (cur.kind == KIND_INSERT) ? edge_counter + TOTAL_W'(1)
                                                        : edge_counter - TOTAL_W'(1);
          state_next = ST_EDGE_B;
        end else begin
          state_next = ST_DONE;
        end
      end

      ST_EDGE_B: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = cur.vertex_b;
        mem_req.wr_data = rd_data ^ (SET_W'(1) << cur.vertex_a);
        state_next      = ST_DONE;
      end

      ST_SWEEP: begin
        if (idx < lim) begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = idx[VERTEX_W-1:0];
          idx_next        = idx + COUNT_W'(1);
        end
        if (rd_pend) begin
          if (cur.kind == KIND_CLIQUE) begin
            if (unit_res.clique_fail) begin
              answer_next = 1'b0;
              state_next  = ST_DONE;
            end else if (last) begin
              state_next = ST_DONE;
            end
          end else begin
            reached_next = unit_res.path_next;
            if (unit_res.path_next[cur.path_to]) begin
              answer_next = 1'b1;
              state_next  = ST_DONE;
            end else if (last) begin
              if (grew || grow_now) begin
                idx_next  = '0;
                grew_next = 1'b0;
              end else begin
                state_next = ST_DONE;
              end
            end else begin
              grew_next = grew || grow_now;
            end
          end
        end
      end

      ST_DONE: begin
        done       = 1'b1;
        state_next = ST_IDLE;
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign cfg_ready         = (state == ST_IDLE);
  assign result.answer     = answer;
  assign result.status     = status;
  assign result.edge_total = edge_counter;

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held");

  a_write_edge_only: assert property (@(posedge clk) disable iff (rst)
    mem_req.wr_en |-> (state == ST_EDGE_A || state == ST_EDGE_B))
    else $error("row write outside edge update");

  a_count_stable: assert property (@(posedge clk) disable iff (rst)
    (state != ST_EDGE_A) |=> $stable(edge_counter))
    else $error("edge count moved outside edge update");

  a_error_no_answer: assert property (@(posedge clk) disable iff (rst)
    (done && result.status) |-> !result.answer)
    else $error("answer set with error status");

endmodule
`default_nettype wire

FILE: hw/rtl/graph_adjacency_engine.sv
// Insert/remove: check, read row a, write row a and read row b, write row b; an error, a
// self-loop or an unchanged edge ends early. Clique test: L rows read one a cycle, with
// L = min(vertex count, MAX_VERTICES, 32). Path test: up to L sweeps over the single row
// port; one word in flight, start taken only while busy is low.
// The result word shows for one cycle on done; the receiver cannot stall.
// Reset: all rows read empty at once (per-row valid flops), edge count 0, count 32.
`default_nettype none
module graph_adjacency_engine #(
  parameter int MAX_VERTICES = gae_pkg::DEF_MAX_VERTICES
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  gae_pkg::item_t              item,
  output logic                        done,
  output gae_pkg::result_t            result,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [gae_pkg::COUNT_W-1:0] cfg_data
);
  import gae_pkg::*;

  localparam int ROWS = (MAX_VERTICES < ROW_LIMIT) ? MAX_VERTICES : ROW_LIMIT;

  mem_req_t         mem_req;
  logic [SET_W-1:0] rd_data;

  gae_adj_mem #(
    .ROWS (ROWS)
  ) u_mem (
    .clk     (clk),
    .rst     (rst),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  gae_ctrl #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .item      (item),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .mem_req   (mem_req),
    .rd_data   (rd_data)
  );

endmodule
`default_nettype wire
